// ===== rtl/piecewise_linear_interpolator_macros.svh =====
// assertion helpers for the rtl
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_MACROS_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define PWLI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PWLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pwli_pkg.sv =====
`default_nettype none

package pwli_pkg;

  // table depth default
  localparam int DEF_POINTS = 16;
  localparam int MIN_POINTS = 2;

  // port widths
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_DATA_W = 5;
  localparam int COUNT_W    = 5;

  // arithmetic widths
  localparam int VAL_W     = 32;
  localparam int DIV_STEPS = 34;
  localparam int QUO_W     = 35;

  // opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // configuration register indexes
  localparam logic CFG_POINT_COUNT  = 1'b0;
  localparam logic CFG_ALLOW_EXTRAP = 1'b1;

  // status from the multiply/divide unit
  typedef struct packed {
    logic done;
    logic ovf;
  } md_stat_t;

endpackage

`default_nettype wire

// ===== rtl/pwli_ram.sv =====
`default_nettype none

module pwli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/pwli_muldiv.sv =====
`default_nettype none

module pwli_muldiv (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [pwli_pkg::VAL_W-1:0]    a,
  input  wire logic [pwli_pkg::VAL_W-1:0]    b,
  input  wire logic [pwli_pkg::VAL_W-1:0]    d,
  output      logic [pwli_pkg::QUO_W-1:0]    q,
  output      pwli_pkg::md_stat_t            stat
);

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_MUL_HI,
    MD_MUL_LO,
    MD_CHECK,
    MD_DIV,
    MD_RND
  } md_state_t;

  md_state_t   state_r;
  logic [31:0] a_r;
  logic [31:0] b_r;
  logic [31:0] d_r;
  logic [63:0] prod_r;
  logic [31:0] rem_r;
  logic [5:0]  cnt_r;
  logic        ovf_r;

  logic [15:0] mul_sel;
  logic [47:0] mul_p;
  logic [32:0] trial;
  logic        trial_ge;
  logic [32:0] trial_diff;
  logic        round_up;

  // one 32x16 multiplier, used for the upper then the lower half of b
  assign mul_sel = (state_r == MD_MUL_HI) ? b_r[31:16] : b_r[15:0];
  assign mul_p   = a_r * mul_sel;

  // restoring division step: shift in the next dividend bit, try subtract
  assign trial      = {rem_r, prod_r[33]};
  assign trial_ge   = trial >= {1'b0, d_r};
  assign trial_diff = trial - {1'b0, d_r};

  // round half up on the magnitude
  assign round_up = {rem_r, 1'b0} >= {1'b0, d_r};
  assign q        = {1'b0, prod_r[33:0]} + pwli_pkg::QUO_W'(round_up);

  assign stat.done = (state_r == MD_RND);
  assign stat.ovf  = ovf_r;

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      case (state_r)
        MD_IDLE: begin
          if (start) begin
            a_r     <= a;
            b_r     <= b;
            d_r     <= d;
            state_r <= MD_MUL_HI;
          end
        end
        MD_MUL_HI: begin
          prod_r  <= {16'b0, mul_p};
          state_r <= MD_MUL_LO;
        end
        MD_MUL_LO: begin
          prod_r  <= (prod_r << 16) + {16'b0, mul_p};
          state_r <= MD_CHECK;
        end
        MD_CHECK: begin
          // quotient of 2^34 or more saturates any 32-bit result
          if ({2'b0, prod_r[63:34]} >= d_r) begin
            ovf_r   <= 1'b1;
            state_r <= MD_RND;
          end else begin
            ovf_r   <= 1'b0;
            rem_r   <= {2'b0, prod_r[63:34]};
            cnt_r   <= 6'(pwli_pkg::DIV_STEPS - 1);
            state_r <= MD_DIV;
          end
        end
        MD_DIV: begin
          rem_r         <= trial_ge ? trial_diff[31:0] : trial[31:0];
          prod_r[33:0]  <= {prod_r[32:0], trial_ge};
          if (cnt_r == '0) begin
            state_r <= MD_RND;
          end else begin
            cnt_r <= cnt_r - 6'd1;
          end
        end
        MD_RND: begin
          state_r <= MD_IDLE;
        end
        default: begin
          state_r <= MD_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/piecewise_linear_interpolator.sv =====
// Piecewise linear interpolation over a table of signed Q16.16 breakpoints.
// Input stream: in_tuser is the opcode. A write request stores point_x and
// point_y at point_index (indexes at or past POINTS are dropped) and yields
// no result. A query request gives query_x and yields one result on the
// output stream: interp_y in out_tdata, saturated and zero_width in out_tuser.
// Configuration: cfg_we/cfg_index/cfg_wdata set point_count and
// allow_extrapolation; write them only while the block is idle.
// Operation: a write is stored while the block stays idle, so writes can be
// accepted back to back. A query first tests the last segment, else a linear
// search probes up to point_count-2 breakpoints; each probe costs one table
// read and one compare. Then the multiply/divide unit runs two 32x16 multiply
// passes and a 34-step restoring division. A quotient too large for 34 bits
// skips the division, and a zero-width segment does not use the unit at all.
// in_tready is high only while no query is in progress.
// The output register parts the two sides: a new request can be accepted
// while a result waits; a finished query holds until that register is free.
// Reset (synchronous, rst_n low) clears control state and the registers to
// point_count = 2, extrapolation off; the table contents are undefined until
// written.
`default_nettype none

`include "piecewise_linear_interpolator_macros.svh"

module piecewise_linear_interpolator #(
  parameter int POINTS = pwli_pkg::DEF_POINTS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // in_tdata: point_index[3:0], point_x[35:4], point_y[67:36], query_x[99:68]
  input  wire logic [pwli_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: opcode[0]
  input  wire logic                              in_tuser,
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  // out_tdata: interp_y[31:0]
  output      logic [pwli_pkg::OUT_DATA_W-1:0]   out_tdata,
  // out_tuser: saturated[0], zero_width[1]
  output      logic [1:0]                        out_tuser,
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_index,
  input  wire logic [pwli_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int AW = $clog2(POINTS);
  localparam int NW = ($clog2(POINTS + 1) > pwli_pkg::COUNT_W) ?
                      $clog2(POINTS + 1) : pwli_pkg::COUNT_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_LAST,
    S_CMP_LAST,
    S_RD_SCAN,
    S_CMP_SCAN,
    S_RD_L,
    S_RD_R,
    S_LOAD_R,
    S_PREP,
    S_ABS,
    S_WAIT,
    S_OUT
  } state_t;

  // input fields
  logic [3:0]         in_point_index;
  logic signed [31:0] in_point_x;
  logic signed [31:0] in_point_y;
  logic signed [31:0] in_query_x;

  assign in_point_index = in_tdata[3:0];
  assign in_point_x     = in_tdata[35:4];
  assign in_point_y     = in_tdata[67:36];
  assign in_query_x     = in_tdata[99:68];

  // configuration registers
  logic [pwli_pkg::COUNT_W-1:0] cfg_count_r;
  logic                         cfg_extrap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r  <= pwli_pkg::COUNT_W'(pwli_pkg::MIN_POINTS);
      cfg_extrap_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        pwli_pkg::CFG_POINT_COUNT:  cfg_count_r  <= cfg_wdata;
        pwli_pkg::CFG_ALLOW_EXTRAP: cfg_extrap_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  state_t             state_r;
  logic signed [31:0] x_r;
  logic [AW-1:0]      seg_last_r;
  logic [AW-1:0]      seg_r;
  logic signed [31:0] xl_r;
  logic signed [31:0] yl_r;
  logic signed [31:0] xr_r;
  logic signed [31:0] yr_r;
  logic signed [32:0] dy_r;
  logic signed [32:0] ex_r;
  logic signed [32:0] den_r;
  logic signed [31:0] ybase_r;
  logic               neg_r;
  logic [31:0]        res_r;
  logic               sat_r;
  logic               zw_r;
  logic               out_tvalid_r;
  logic [31:0]        out_y_r;
  logic [1:0]         out_flags_r;

  logic in_acc;
  logic wr_en;
  logic in_query_acc;
  logic write_quiet;
  assign in_tready    = (state_r == S_IDLE);
  assign in_acc       = in_tvalid && in_tready;
  assign wr_en        = in_acc && (in_tuser == pwli_pkg::OP_WRITE) &&
                        (32'(in_point_index) < POINTS);
  assign in_query_acc = in_acc && (in_tuser == pwli_pkg::OP_QUERY);
  assign write_quiet  = in_acc && (in_tuser == pwli_pkg::OP_WRITE) && !out_tvalid_r;

  // clamp the configured count into the table, index of the last segment
  logic [NW-1:0] cnt_ext;
  logic [NW-1:0] n_c;
  logic [AW-1:0] seg_last_c;
  always_comb begin
    cnt_ext = NW'(cfg_count_r);
    if (cnt_ext < NW'(pwli_pkg::MIN_POINTS)) begin
      n_c = NW'(pwli_pkg::MIN_POINTS);
    end else if (cnt_ext > NW'(POINTS)) begin
      n_c = NW'(POINTS);
    end else begin
      n_c = cnt_ext;
    end
    seg_last_c = AW'(n_c - NW'(pwli_pkg::MIN_POINTS));
  end

  // table read address
  logic [AW-1:0] rd_addr;
  always_comb begin
    case (state_r)
      S_RD_LAST:          rd_addr = seg_last_r;
      S_RD_SCAN, S_RD_R:  rd_addr = seg_r + AW'(1);
      default:            rd_addr = seg_r;
    endcase
  end

  logic [31:0] x_rd;
  logic [31:0] y_rd;

  pwli_ram #(.WIDTH(pwli_pkg::VAL_W), .DEPTH(POINTS)) u_x_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(in_point_index)),
    .wdata (in_point_x),
    .raddr (rd_addr),
    .rdata (x_rd)
  );

  pwli_ram #(.WIDTH(pwli_pkg::VAL_W), .DEPTH(POINTS)) u_y_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(in_point_index)),
    .wdata (in_point_y),
    .raddr (rd_addr),
    .rdata (y_rd)
  );

  // clamp the segment end values when extrapolation is off
  logic signed [31:0] yr_c;
  logic signed [31:0] yl_c;
  always_comb begin
    yr_c = (!cfg_extrap_r && (x_r < xl_r)) ? yl_r : yr_r;
    yl_c = (!cfg_extrap_r && (x_r > xr_r)) ? yr_c : yl_r;
  end

  // magnitudes for the multiply/divide unit
  logic [32:0] dy_abs;
  logic [32:0] ex_abs;
  logic [32:0] den_abs;
  assign dy_abs  = dy_r[32]  ? -dy_r  : dy_r;
  assign ex_abs  = ex_r[32]  ? -ex_r  : ex_r;
  assign den_abs = den_r[32] ? -den_r : den_r;

  logic                       md_start;
  logic [pwli_pkg::QUO_W-1:0] md_q;
  pwli_pkg::md_stat_t         md_stat;

  assign md_start = (state_r == S_ABS) && (den_r != '0);

  pwli_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .a     (dy_abs[31:0]),
    .b     (ex_abs[31:0]),
    .d     (den_abs[31:0]),
    .q     (md_q),
    .stat  (md_stat)
  );

  // add the signed quotient to the base y and saturate
  logic [36:0]        q_ext;
  logic signed [36:0] sum;
  logic               sum_ovf;
  always_comb begin
    q_ext   = {2'b00, md_q};
    sum     = 37'(signed'(ybase_r)) + (neg_r ? -signed'(q_ext) : signed'(q_ext));
    sum_ovf = (sum[36:31] != {6{sum[36]}});
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      // output handshake outside S_OUT, which handles its own
      if (out_tvalid_r && out_tready && (state_r != S_OUT)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && (in_tuser == pwli_pkg::OP_QUERY)) begin
            x_r        <= in_query_x;
            seg_last_r <= seg_last_c;
            state_r    <= S_RD_LAST;
          end
        end
        S_RD_LAST: begin
          state_r <= S_CMP_LAST;
        end
        S_CMP_LAST: begin
          // x at or past the last segment's left end, or a single segment, needs no search
          if ((x_r >= signed'(x_rd)) || (seg_last_r == '0)) begin
            seg_r   <= seg_last_r;
            state_r <= S_RD_L;
          end else begin
            seg_r   <= '0;
            state_r <= S_RD_SCAN;
          end
        end
        S_RD_SCAN: begin
          state_r <= S_CMP_SCAN;
        end
        S_CMP_SCAN: begin
          // stop at the first right end at or above x
          if ((x_r <= signed'(x_rd)) || (seg_r + AW'(1) == seg_last_r)) begin
            state_r <= S_RD_L;
          end else begin
            seg_r   <= seg_r + AW'(1);
            state_r <= S_RD_SCAN;
          end
        end
        S_RD_L: begin
          state_r <= S_RD_R;
        end
        S_RD_R: begin
          xl_r    <= x_rd;
          yl_r    <= y_rd;
          state_r <= S_LOAD_R;
        end
        S_LOAD_R: begin
          xr_r    <= x_rd;
          yr_r    <= y_rd;
          state_r <= S_PREP;
        end
        S_PREP: begin
          dy_r    <= 33'(yr_c) - 33'(yl_c);
          ex_r    <= 33'(x_r) - 33'(xl_r);
          den_r   <= 33'(xr_r) - 33'(xl_r);
          ybase_r <= yl_c;
          state_r <= S_ABS;
        end
        S_ABS: begin
          if (den_r == '0) begin
            // zero-width segment returns the stored left y
            res_r   <= yl_r;
            sat_r   <= 1'b0;
            zw_r    <= 1'b1;
            state_r <= S_OUT;
          end else begin
            neg_r   <= dy_r[32] ^ ex_r[32] ^ den_r[32];
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (md_stat.done) begin
            zw_r <= 1'b0;
            if (md_stat.ovf || sum_ovf) begin
              sat_r <= 1'b1;
              if (md_stat.ovf ? neg_r : sum[36]) begin
                res_r <= 32'h8000_0000;
              end else begin
                res_r <= 32'h7fff_ffff;
              end
            end else begin
              sat_r <= 1'b0;
              res_r <= sum[31:0];
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_y_r      <= res_r;
            out_flags_r  <= {zw_r, sat_r};
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_y_r;
  assign out_tuser  = out_flags_r;

  // checks
  logic out_sat;
  logic out_at_limit;
  assign out_sat      = out_tvalid_r && out_flags_r[0];
  assign out_at_limit = (out_y_r == 32'h7fff_ffff) || (out_y_r == 32'h8000_0000);

  `PWLI_ASSERT_NEXT(a_query_busy, clk, rst_n, in_query_acc, !in_tready, "query left block ready")
  `PWLI_ASSERT_NEXT(a_write_no_result, clk, rst_n, write_quiet, !out_tvalid_r, "write gave result")
  `PWLI_ASSERT_NOW(a_zw_not_sat, clk, rst_n, out_tvalid_r, !(&out_flags_r), "zero-width and saturated")
  `PWLI_ASSERT_NOW(a_sat_value, clk, rst_n, out_sat, out_at_limit, "saturated result not at a limit")

endmodule

`default_nettype wire
